/* rtl/dssm_pkg.sv */
// ----------------------------------------------------------------------------
// Dual stack shared memory package
// Widths, codes and request/response types shared by the stack block.
// ----------------------------------------------------------------------------
package dssm_pkg;

   localparam int DEPTH       = 1024;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int CAP_W       = 11;
   localparam int DATA_W      = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] REQ_PUSH_ONE = 2'd0;
   localparam logic [1:0] REQ_PUSH_TWO = 2'd1;
   localparam logic [1:0] REQ_POP_ONE  = 2'd2;
   localparam logic [1:0] REQ_POP_TWO  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_WRITE,
      OP_READ
   } dssm_op_kind_type;

   typedef struct packed {
      logic [1:0]               req_type;
      logic signed [DATA_W-1:0] push_value;
   } dssm_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pop_value;
      logic [1:0]               status;
   } dssm_rsp_type;

   typedef struct packed {
      dssm_op_kind_type  kind;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic [1:0]        status;
   } dssm_op_type;

endpackage

/* rtl/dssm_front.sv */
// ----------------------------------------------------------------------------
// Dual stack front end
// Holds the capacity and both stack counts, checks each request and turns it
// into a memory operation for the back end.
// ----------------------------------------------------------------------------
module dssm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  dssm_pkg::dssm_req_type      req_item,
   input  logic                        csr_write,
   input  logic [dssm_pkg::CAP_W-1:0]  csr_wdata,
   output dssm_pkg::dssm_op_type       op_out
);

   logic [dssm_pkg::CAP_W-1:0] capacity_ff, capacity_in;
   logic [dssm_pkg::CNT_W-1:0] count_one_ff, count_one_in;
   logic [dssm_pkg::CNT_W-1:0] count_two_ff, count_two_in;
   logic [dssm_pkg::CNT_W-1:0] cap_eff;
   logic [dssm_pkg::CNT_W:0]   used;
   logic                       push_ok;
   logic [dssm_pkg::CNT_W-1:0] addr_full;

   always_comb begin
      // A capacity beyond the memory size saturates to the memory size.
      if ({{(32 - dssm_pkg::CAP_W){1'b0}}, capacity_ff} > 32'(dssm_pkg::DEPTH)) begin
         cap_eff = dssm_pkg::CNT_W'(dssm_pkg::DEPTH);
      end else begin
         cap_eff = dssm_pkg::CNT_W'(capacity_ff);
      end
      used    = {1'b0, count_one_ff} + {1'b0, count_two_ff};
      push_ok = used < {1'b0, cap_eff};
   end

   always_comb begin
      capacity_in    = capacity_ff;
      count_one_in   = count_one_ff;
      count_two_in   = count_two_ff;
      addr_full      = '0;
      op_out.kind    = dssm_pkg::OP_NONE;
      op_out.data    = req_item.push_value;
      op_out.status  = dssm_pkg::ST_OK;
      case (req_item.req_type)
         dssm_pkg::REQ_PUSH_ONE: begin
            if (push_ok) begin
               addr_full    = count_one_ff;
               op_out.kind  = dssm_pkg::OP_WRITE;
               count_one_in = count_one_ff + 1'b1;
            end else begin
               op_out.status = dssm_pkg::ST_OVERFLOW;
            end
         end
         dssm_pkg::REQ_PUSH_TWO: begin
            if (push_ok) begin
               addr_full    = cap_eff - 1'b1 - count_two_ff;
               op_out.kind  = dssm_pkg::OP_WRITE;
               count_two_in = count_two_ff + 1'b1;
            end else begin
               op_out.status = dssm_pkg::ST_OVERFLOW;
            end
         end
         dssm_pkg::REQ_POP_ONE: begin
            if (count_one_ff != '0) begin
               addr_full    = count_one_ff - 1'b1;
               op_out.kind  = dssm_pkg::OP_READ;
               count_one_in = count_one_ff - 1'b1;
            end else begin
               op_out.status = dssm_pkg::ST_UNDERFLOW;
            end
         end
         default: begin
            if (count_two_ff != '0 && count_two_ff <= cap_eff) begin
               addr_full    = cap_eff - count_two_ff;
               op_out.kind  = dssm_pkg::OP_READ;
               count_two_in = count_two_ff - 1'b1;
            end else begin
               op_out.status = dssm_pkg::ST_UNDERFLOW;
            end
         end
      endcase
      op_out.addr = addr_full[dssm_pkg::ADDR_W-1:0];
      if (!accept) begin
         count_one_in = count_one_ff;
         count_two_in = count_two_ff;
      end
      // A new capacity empties both stacks.
      if (csr_write) begin
         capacity_in  = csr_wdata;
         count_one_in = '0;
         count_two_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= dssm_pkg::CAP_W'(1024);
         count_one_ff <= '0;
         count_two_ff <= '0;
      end else begin
         capacity_ff  <= capacity_in;
         count_one_ff <= count_one_in;
         count_two_ff <= count_two_in;
      end
   end

endmodule

/* rtl/dssm_queue.sv */
// ----------------------------------------------------------------------------
// Dual stack operation queue
// Short in-order queue of memory operations between front and back end.
// ----------------------------------------------------------------------------
module dssm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dssm_pkg::dssm_op_type push_op,
   input  logic                  pop,
   output dssm_pkg::dssm_op_type head_op,
   output logic                  empty,
   output logic                  full
);

   dssm_pkg::dssm_op_type       entry_ff [dssm_pkg::QUEUE_DEPTH];
   logic [dssm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dssm_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dssm_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   localparam logic [dssm_pkg::QPTR_W-1:0] LAST = dssm_pkg::QPTR_W'(dssm_pkg::QUEUE_DEPTH - 1);

   assign empty   = count_ff == '0;
   assign full    = count_ff == dssm_pkg::QCNT_W'(dssm_pkg::QUEUE_DEPTH);
   assign head_op = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/dssm_back.sv */
// ----------------------------------------------------------------------------
// Dual stack back end
// Owns the shared memory, carries out one operation per cycle and drives
// the response strobe.
// ----------------------------------------------------------------------------
module dssm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   op_valid,
   input  dssm_pkg::dssm_op_type  op_in,
   output logic                   rsp_strobe,
   output dssm_pkg::dssm_rsp_type rsp_item
);

   logic [dssm_pkg::DATA_W-1:0] mem [dssm_pkg::DEPTH];
   logic [dssm_pkg::DATA_W-1:0] rdata_ff;
   logic                        strobe_ff;
   logic                        read_ok_ff;
   logic [1:0]                  status_ff;

   always_ff @(posedge clock) begin
      if (op_valid && op_in.kind == dssm_pkg::OP_WRITE) begin
         mem[op_in.addr] <= op_in.data;
      end
      rdata_ff <= mem[op_in.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= op_valid;
      end
      read_ok_ff <= op_in.kind == dssm_pkg::OP_READ;
      status_ff  <= op_in.status;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_item.pop_value = read_ok_ff ? rdata_ff : '0;
   assign rsp_item.status    = status_ff;

endmodule

/* rtl/dual_stack_shared_memory.sv */
// ----------------------------------------------------------------------------
// Dual stack shared memory
// Two LIFO stacks in one memory: stack one grows up from entry 0, stack two
// grows down from the top entry of the configured capacity.
// ----------------------------------------------------------------------------
//  channel   ports                          direction  handshake
//  request   start, busy, req_item          in         start & !busy
//  response  rsp_strobe, rsp_item           out        strobe, one cycle
//  config    csr_valid, csr_ready, csr_wdata in        valid & ready
//
// One request is taken per cycle while busy is low; its operation is
// registered in the queue entry, its response in the output registers on
// the single port of the shared memory. Synchronous reset empties both
// stacks and sets the capacity to 1024; memory contents are not cleared.
// busy rises only while the operation queue is full or reset is high. A
// capacity write empties both stacks. Responses cannot be held off.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  dssm_pkg::dssm_req_type     req_item,
   output logic                       rsp_strobe,
   output dssm_pkg::dssm_rsp_type     rsp_item,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [dssm_pkg::CAP_W-1:0] csr_wdata
);

   dssm_pkg::dssm_op_type front_op;
   dssm_pkg::dssm_op_type head_op;
   logic                  accept;
   logic                  q_empty;
   logic                  q_full;

   assign busy      = reset || q_full;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   dssm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_item  (req_item),
      .csr_write (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .op_out    (front_op)
   );

   dssm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .push_op (front_op),
      .pop     (!q_empty),
      .head_op (head_op),
      .empty   (q_empty),
      .full    (q_full)
   );

   dssm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (!q_empty),
      .op_in      (head_op),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // Every response comes from an accepted request, through the queue entry and the back-end output registers.
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("response without a matching request");

   // A failed request never returns data.
   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != dssm_pkg::ST_OK) |-> rsp_item.pop_value == '0)
      else $error("failed request returned data");

   // The back end drains one operation per cycle, so the queue never fills.
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !q_full)
      else $error("operation queue filled up");

endmodule

/* bench/stack_checker_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual stack checker
// Mirrors the two stacks in a private copy of the shared store and checks
// each response against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package stack_checker_pkg;

   localparam int unsigned CAPACITY_AT_RESET = 1024;
   localparam int unsigned MISMATCH_PRINTS   = 10;

   class stack_checker;

      bit [dssm_pkg::DATA_W-1:0] store_mirror [dssm_pkg::DEPTH];
      int unsigned               depth_one;
      int unsigned               depth_two;
      int unsigned               capacity;
      dssm_pkg::dssm_rsp_type    awaited_results [$];

      int unsigned               mismatches;
      int unsigned               requests_seen;
      int unsigned               pushes_stored;
      int unsigned               pops_served;
      int unsigned               overflows;
      int unsigned               underflows;

      function new();
         depth_one     = 0;
         depth_two     = 0;
         capacity      = CAPACITY_AT_RESET;
         mismatches    = 0;
         requests_seen = 0;
         pushes_stored = 0;
         pops_served   = 0;
         overflows     = 0;
         underflows    = 0;
      endfunction

      // A capacity write empties both stacks; the stored words stay but are
      // no longer reachable.
      function void write_capacity(logic [dssm_pkg::CAP_W-1:0] value);
         capacity  = value;
         depth_one = 0;
         depth_two = 0;
      endfunction

      function int unsigned pending();
         return awaited_results.size();
      endfunction

      function dssm_pkg::dssm_rsp_type predict_stack_op(dssm_pkg::dssm_req_type req);
         dssm_pkg::dssm_rsp_type result;
         int unsigned            usable;
         int unsigned            slot;
         result.pop_value = '0;
         result.status    = dssm_pkg::ST_OK;
         usable = (capacity > dssm_pkg::DEPTH) ? dssm_pkg::DEPTH : capacity;
         case (req.req_type)
            dssm_pkg::REQ_PUSH_ONE, dssm_pkg::REQ_PUSH_TWO: begin
               if (depth_one + depth_two < usable) begin
                  if (req.req_type == dssm_pkg::REQ_PUSH_ONE) begin
                     slot = depth_one;
                     depth_one++;
                  end else begin
                     slot = usable - 1 - depth_two;
                     depth_two++;
                  end
                  store_mirror[slot] = req.push_value;
               end else begin
                  result.status = dssm_pkg::ST_OVERFLOW;
               end
            end
            dssm_pkg::REQ_POP_ONE: begin
               if (depth_one > 0) begin
                  depth_one--;
                  result.pop_value = store_mirror[depth_one];
               end else begin
                  result.status = dssm_pkg::ST_UNDERFLOW;
               end
            end
            default: begin
               if (depth_two > 0 && depth_two <= usable) begin
                  result.pop_value = store_mirror[usable - depth_two];
                  depth_two--;
               end else begin
                  result.status = dssm_pkg::ST_UNDERFLOW;
               end
            end
         endcase
         return result;
      endfunction

      function void note_request(dssm_pkg::dssm_req_type req);
         dssm_pkg::dssm_rsp_type result;
         result = predict_stack_op(req);
         requests_seen++;
         if (result.status == dssm_pkg::ST_OVERFLOW) begin
            overflows++;
         end else if (result.status == dssm_pkg::ST_UNDERFLOW) begin
            underflows++;
         end else if (req.req_type == dssm_pkg::REQ_PUSH_ONE ||
                      req.req_type == dssm_pkg::REQ_PUSH_TWO) begin
            pushes_stored++;
         end else begin
            pops_served++;
         end
         awaited_results.push_back(result);
      endfunction

      function void record_mismatch(string text);
         mismatches++;
         if (mismatches <= MISMATCH_PRINTS) begin
            $display("ERROR: %s", text);
         end
      endfunction

      function void check_response(dssm_pkg::dssm_rsp_type got);
         dssm_pkg::dssm_rsp_type want;
         if (awaited_results.size() == 0) begin
            record_mismatch($sformatf("response (pop_value %0d, status %0d) with no request open",
                                      got.pop_value, got.status));
            return;
         end
         want = awaited_results.pop_front();
         if (got.pop_value !== want.pop_value) begin
            record_mismatch($sformatf("pop_value expected %0d, got %0d",
                                      want.pop_value, got.pop_value));
         end
         if (got.status !== want.status) begin
            record_mismatch($sformatf("status expected %0d, got %0d", want.status, got.status));
         end
      endfunction

   endclass

endpackage

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual stack shared memory testbench
// Drives push and pop requests on both stacks under a range of capacities,
// from zero through saturation above the array size, with and without gaps
// between requests, and checks every response against a mirrored model.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASES      = 12;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   dssm_pkg::dssm_req_type           req_item;
   logic                             rsp_strobe;
   dssm_pkg::dssm_rsp_type           rsp_item;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [dssm_pkg::CAP_W-1:0]       csr_wdata;

   stack_checker_pkg::stack_checker  checker_h;
   int unsigned                      cycle_count = 0;
   int unsigned                      idle_pct;
   int unsigned                      capacity_writes;

   // Per-phase capacity, request count, sender idle percentage, push share.
   int unsigned         phase_capacity [PHASES];
   int unsigned         phase_requests [PHASES];
   int unsigned         phase_idle     [PHASES];
   int unsigned         phase_push     [PHASES];

   dual_stack_shared_memory u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Requests are noted when taken; responses are checked in arrival order.
   always @(posedge clock) begin
      if (!reset && checker_h != null) begin
         if (start && !busy) begin
            checker_h.note_request(req_item);
         end
         if (rsp_strobe) begin
            checker_h.check_response(rsp_item);
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles", cycle_count);
      $display("dual_stack_shared_memory: mismatch");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic issue_request(logic [1:0] kind, logic [dssm_pkg::DATA_W-1:0] value);
      dssm_pkg::dssm_req_type req;
      req.req_type   = kind;
      req.push_value = value;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= req;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      while (checker_h.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(logic [dssm_pkg::CAP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      checker_h.write_capacity(value);
      capacity_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [dssm_pkg::DATA_W-1:0] random_value();
      case ($urandom_range(0, 15))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic issue_random(int unsigned push_pct);
      logic [1:0] kind;
      if ($urandom_range(0, 99) < push_pct) begin
         kind = $urandom_range(0, 1) ? dssm_pkg::REQ_PUSH_TWO : dssm_pkg::REQ_PUSH_ONE;
      end else begin
         kind = $urandom_range(0, 1) ? dssm_pkg::REQ_POP_TWO : dssm_pkg::REQ_POP_ONE;
      end
      issue_request(kind, random_value());
   endtask

   initial begin
      checker_h       = new();
      idle_pct        = 0;
      capacity_writes = 0;
      reset           = 1'b1;
      start           = 1'b0;
      req_item        = '0;
      csr_valid       = 1'b0;
      csr_wdata       = '0;

      phase_capacity = '{4,  1,  7,  0,  2,  16, 2047, 1024, 1025, 3,  1023, 5};
      phase_requests = '{60, 40, 60, 20, 50, 80, 370,  80,   40,   60, 50,   60};
      phase_idle     = '{0,  87, 26, 0,  87, 0,  26,   87,   0,    26, 0,    87};
      phase_push     = '{50, 50, 55, 50, 50, 60, 97,   50,   40,   50, 55,   70};

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Capacity at its reset value: empty pops, extreme values on both
      // stacks, and pops in reverse order.
      issue_request(dssm_pkg::REQ_POP_ONE, 32'h0);
      issue_request(dssm_pkg::REQ_POP_TWO, 32'hFFFF_FFFF);
      issue_request(dssm_pkg::REQ_PUSH_ONE, 32'h7FFF_FFFF);
      issue_request(dssm_pkg::REQ_PUSH_TWO, 32'h8000_0000);
      issue_request(dssm_pkg::REQ_PUSH_ONE, 32'h0000_0000);
      issue_request(dssm_pkg::REQ_PUSH_TWO, 32'hFFFF_FFFF);
      issue_request(dssm_pkg::REQ_POP_TWO, 32'h0);
      issue_request(dssm_pkg::REQ_POP_ONE, 32'h0);
      issue_request(dssm_pkg::REQ_POP_ONE, 32'h0);
      issue_request(dssm_pkg::REQ_POP_TWO, 32'h0);
      issue_request(dssm_pkg::REQ_POP_ONE, 32'h0);
      start <= 1'b0;
      drain_responses();

      // Zero capacity: nothing can be stored.
      write_capacity(11'd0);
      issue_request(dssm_pkg::REQ_PUSH_ONE, 32'h1234_5678);
      issue_request(dssm_pkg::REQ_PUSH_TWO, 32'h8765_4321);
      issue_request(dssm_pkg::REQ_POP_ONE, 32'h0);
      issue_request(dssm_pkg::REQ_POP_TWO, 32'h0);
      start <= 1'b0;
      drain_responses();

      // One entry shared by both stacks; the last push stays stored so the
      // next capacity write has something to discard.
      write_capacity(11'd1);
      issue_request(dssm_pkg::REQ_PUSH_TWO, 32'hA5A5_5A5A);
      issue_request(dssm_pkg::REQ_PUSH_ONE, 32'h1111_1111);
      issue_request(dssm_pkg::REQ_POP_ONE, 32'h0);
      issue_request(dssm_pkg::REQ_POP_TWO, 32'h0);
      issue_request(dssm_pkg::REQ_PUSH_ONE, 32'h5A5A_A5A5);
      issue_request(dssm_pkg::REQ_POP_TWO, 32'h0);
      start <= 1'b0;
      drain_responses();

      write_capacity(11'd2);
      issue_request(dssm_pkg::REQ_POP_ONE, 32'h0);
      issue_request(dssm_pkg::REQ_PUSH_TWO, 32'h0F0F_F0F0);
      issue_request(dssm_pkg::REQ_POP_TWO, 32'h0);
      start <= 1'b0;
      drain_responses();

      for (int p = 0; p < PHASES; p++) begin
         write_capacity(phase_capacity[p][dssm_pkg::CAP_W-1:0]);
         idle_pct = phase_idle[p];
         repeat (phase_requests[p]) issue_random(phase_push[p]);
         start <= 1'b0;
         drain_responses();
      end

      $display("Covered %0d requests over %0d capacity settings, 0 to 2047.",
               checker_h.requests_seen, capacity_writes);
      $display("Stored %0d, popped %0d, overflows %0d, underflows %0d, errors %0d.",
               checker_h.pushes_stored, checker_h.pops_served, checker_h.overflows,
               checker_h.underflows, checker_h.mismatches);
      if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
         $display("dual_stack_shared_memory: match");
      end else begin
         $display("dual_stack_shared_memory: mismatch");
      end
      $finish;
   end

endmodule
